// File: hdl/hcd_pkg.sv
package hcd_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int NMS_RADIUS_DEF = 2;

    // Field and register widths.
    localparam int PIX_W     = 8;
    localparam int GRAD_W    = 11;
    localparam int GPAIR_W   = 2 * GRAD_W;
    localparam int RESP_W    = 23;
    localparam int IMG_W_W   = 11;
    localparam int IMG_H_W   = 13;
    localparam int THR_W     = 19;
    localparam int ROW_W     = 12;
    localparam int OCOL_W    = 10;
    localparam int H_MAX     = 4096;
    localparam int CFG_IDX_W = 2;

    // Line ring geometry: sixteen rows.
    localparam int RING_W = 4;

    // Arithmetic widths.
    localparam int POS_W  = 25;
    localparam int ACC_W  = 38;
    localparam int ABC_W  = 26;
    localparam int NUM_W  = 2 * ABC_W;
    localparam int DEN_W  = ABC_W + 1;
    localparam int ITER_W = 6;
    localparam int WT_W   = 14;
    localparam int WIN_W  = 4;

    localparam logic [RESP_W-1:0] RESP_MAX = {RESP_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 2'd2;

    localparam logic [ITER_W-1:0] ITERS_POS  = ITER_W'(POS_W);
    localparam logic [ITER_W-1:0] ITERS_RESP = ITER_W'(NUM_W);

    typedef struct packed {
        logic              start;
        logic [ITER_W-1:0] iters;
        logic [NUM_W-1:0]  dividend;
        logic [DEN_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quot;
        logic [DEN_W-1:0] rem;
    } t_div_rsp;

    // Q0.16 Gaussian weight of the 6x6 smoothing window, symmetric about its center.
    function automatic logic [WT_W-1:0] gauss_weight(input logic [WIN_W-1:0] tr,
                                                     input logic [WIN_W-1:0] tc);
        logic [WIN_W-1:0] mr;
        logic [WIN_W-1:0] mc;
        logic [3:0]       key;
        logic [WT_W-1:0]  wt;
        mr  = (tr < WIN_W'(3)) ? tr : WIN_W'(5) - tr;
        mc  = (tc < WIN_W'(3)) ? tc : WIN_W'(5) - tc;
        key = {mr[1:0], mc[1:0]};
        case (key)
            4'd0:    wt = WT_W'(20);
            4'd1:    wt = WT_W'(151);
            4'd2:    wt = WT_W'(406);
            4'd4:    wt = WT_W'(151);
            4'd5:    wt = WT_W'(1101);
            4'd6:    wt = WT_W'(3002);
            4'd8:    wt = WT_W'(406);
            4'd9:    wt = WT_W'(3002);
            4'd10:   wt = WT_W'(8153);
            default: wt = '0;
        endcase
        return wt;
    endfunction

endpackage

// File: hdl/hcd_ram.sv
module hcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/hcd_div.sv
module hcd_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hcd_pkg::t_div_req i_req,
    output hcd_pkg::t_div_rsp o_rsp
);
    import hcd_pkg::*;

    // Restoring divider, one quotient bit per cycle. A short dividend is placed in
    // the upper bits and run for fewer iterations.
    logic              r_busy;
    logic              r_done;
    logic [ITER_W-1:0] r_cnt;
    logic [NUM_W-1:0]  r_q;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_div;

    logic [DEN_W:0]    rem_sh;
    logic [DEN_W+1:0]  diff;

    always_comb begin
        rem_sh = {r_rem, r_q[NUM_W-1]};
        diff   = {1'b0, rem_sh} - {2'b00, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_req.start && r_busy && (r_cnt == ITER_W'(1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.iters;
                r_q    <= i_req.dividend;
                r_rem  <= '0;
                r_div  <= i_req.divisor;
            end else if (r_busy) begin
                if (!diff[DEN_W+1]) begin
                    r_rem <= diff[DEN_W-1:0];
                    r_q   <= {r_q[NUM_W-2:0], 1'b1};
                end else begin
                    r_rem <= rem_sh[DEN_W-1:0];
                    r_q   <= {r_q[NUM_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - ITER_W'(1);
                if (r_cnt == ITER_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;
    assign o_rsp.rem  = r_rem;

endmodule

// File: hdl/harris_corner_detector_unit.sv
// Channel        | Direction | Signals                        | Contents
// ---------------+-----------+--------------------------------+------------------------------------
// Pixel stream   | in        | i_s_axis_tvalid/o_s_axis_tready| tdata: pixel; tuser: operation
// Result stream  | out       | o_m_axis_tvalid/i_m_axis_tready| tdata: row, col, response;
//                |           |                                | tuser: is_corner; tlast: frame end
// Configuration  | in        | i_cfg_valid/o_cfg_ready        | i_cfg_index, i_cfg_data
//
// Items for a position that no stage uses are the quickest, those in the frame interior the
// slowest. The time is set by the shared bit-serial divider (a quotient for each of up to four
// raster positions, and the response quotient) and by the single read port of each line
// memory (9, 36 and NMS window taps, each pass followed by a drain of the tap pipeline).
// After reset all 16 * 2^clog2(MAX_WIDTH) entries of the pixel line memory are cleared, one
// entry per cycle; no pixel transaction is taken then, but configuration writes are.
// A finished result waits in the output register while the next pixel is processed; only the
// final step of an item that has a result waits for that register to drain.
module harris_corner_detector_unit #(
    parameter int MAX_WIDTH  = hcd_pkg::MAX_WIDTH_DEF,
    parameter int NMS_RADIUS = hcd_pkg::NMS_RADIUS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Pixel stream.
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [7:0]                    i_s_axis_tdata,   // [7:0] pixel
    input  logic [0:0]                    i_s_axis_tuser,   // [0] operation
    // Result stream.
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [47:0]                   o_m_axis_tdata,   // [11:0] out_row, [21:12] out_col,
                                                            // [44:22] corner_response, zero pad
    output logic [0:0]                    o_m_axis_tuser,   // [0] is_corner
    output logic                          o_m_axis_tlast,   // last_of_frame
    // Configuration write.
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [hcd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [hcd_pkg::THR_W-1:0]     i_cfg_data
);
    import hcd_pkg::*;

    localparam int COLW      = $clog2(MAX_WIDTH);
    localparam int AW        = RING_W + COLW;
    localparam int DEPTH     = 16 << COLW;
    localparam int NMS_N     = 2 * NMS_RADIUS + 1;
    localparam int LAG_O_MUL = 4 + NMS_RADIUS;
    localparam int TR_W      = ROW_W + 2;
    localparam int TC_W      = COLW + 2;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_SETUP, S_FLAGS, S_DIV_GO, S_DIV_WAIT, S_STORE, S_TAP,
        S_GRAD_WR, S_ABC, S_MUL, S_NUM, S_QDIV_WAIT, S_RESP_WR, S_FIN
    } t_state;

    typedef enum logic [1:0] {PH_GRAD, PH_RESP, PH_NMS} t_phase;

    t_state r_state;
    t_phase r_phase;

    // Configuration registers.
    logic [IMG_W_W-1:0] r_img_w;
    logic [IMG_H_W-1:0] r_img_h;
    logic [THR_W-1:0]   r_thr;

    // Raster position of the next transaction.
    logic [IMG_H_W-1:0] r_in_row;
    logic [COLW-1:0]    r_in_col;
    logic [IMG_H_W-1:0] n_in_row;
    logic [COLW-1:0]    n_in_col;

    logic [AW-1:0]      r_clr_addr;

    // Per-item context.
    logic               r_op;
    logic [PIX_W-1:0]   r_pix;
    logic [IMG_W_W-1:0] r_w;
    logic [IMG_H_W-1:0] r_h;
    logic [POS_W-1:0]   r_idx, r_hw, r_lag_g, r_lag_s, r_lag_o;
    logic [3:0]         r_en;
    logic               r_last;
    logic               r_adv;
    logic [1:0]         r_dsel;
    logic [ROW_W-1:0]   r_pr [4];
    logic [COLW-1:0]    r_pc [4];

    // Tap sequencer and its pipeline.
    logic [WIN_W-1:0]   r_tr, r_tc;
    logic               r_iss_done;
    logic [1:0]         r_drain;
    logic               r_s1_vld, r_s1_ctr;
    logic [WIN_W-1:0]   r_s1_tr, r_s1_tc;
    logic               r_s2_vld;
    logic signed [GPAIR_W-1:0] r_pxx, r_pyy, r_pxy;
    logic [WT_W-1:0]    r_s2_wt;
    logic               r_s3_vld;
    logic signed [ACC_W-1:0] r_wxx, r_wyy, r_wxy;

    // Accumulators and response math.
    logic signed [GRAD_W-1:0] r_gx, r_gy;
    logic signed [ACC_W-1:0]  r_sxx, r_syy, r_sxy;
    logic [RESP_W-1:0]  r_mx, r_ctr, r_rq;
    logic [ABC_W-1:0]   r_a, r_b, r_c;
    logic [NUM_W-1:0]   r_ab, r_cc;
    logic [DEN_W-1:0]   r_den;
    t_div_req           r_div_req;
    t_div_rsp           div_rsp;

    // Output register.
    logic               r_out_vld;
    logic [ROW_W-1:0]   r_out_row;
    logic [OCOL_W-1:0]  r_out_col;
    logic [RESP_W-1:0]  r_out_resp;
    logic               r_out_corner;
    logic               r_out_last;

    // Effective geometry: width clamped to 1..MAX_WIDTH, height to 1..4096.
    logic [IMG_W_W-1:0] w_eff;
    logic [IMG_H_W-1:0] h_eff;
    logic [POS_W-1:0]   lag_g_c;

    always_comb begin
        if (r_img_w == '0) begin
            w_eff = IMG_W_W'(1);
        end else if (32'(r_img_w) > MAX_WIDTH) begin
            w_eff = IMG_W_W'(MAX_WIDTH);
        end else begin
            w_eff = r_img_w;
        end
        if (r_img_h == '0) begin
            h_eff = IMG_H_W'(1);
        end else if (32'(r_img_h) > H_MAX) begin
            h_eff = IMG_H_W'(H_MAX);
        end else begin
            h_eff = r_img_h;
        end
        lag_g_c = POS_W'(w_eff) + POS_W'(1);
    end

    // Delayed raster positions of the gradient, response and result stages.
    logic [POS_W-1:0] d_g, d_s, d_o, div_val;
    logic             ge_g, ge_s, ge_o, en_g, en_s, en_o, last_c;

    always_comb begin
        d_g    = r_idx - r_lag_g;
        d_s    = r_idx - r_lag_s;
        d_o    = r_idx - r_lag_o;
        ge_g   = r_idx >= r_lag_g;
        ge_s   = r_idx >= r_lag_s;
        ge_o   = r_idx >= r_lag_o;
        en_g   = ge_g && (d_g < r_hw);
        en_s   = ge_s && (d_s < r_hw);
        en_o   = ge_o && (d_o < r_hw);
        last_c = en_o && (d_o == r_hw - POS_W'(1));
        case (r_dsel)
            2'd0:    div_val = r_idx;
            2'd1:    div_val = d_g;
            2'd2:    div_val = d_s;
            default: div_val = d_o;
        endcase
    end

    // Window geometry of the current tap phase.
    logic [WIN_W-1:0]        win_n, win_off;
    logic [ROW_W-1:0]        base_r;
    logic [COLW-1:0]         base_c;
    logic signed [TR_W-1:0]  tap_r;
    logic signed [TC_W-1:0]  tap_c;
    logic                    tap_in, tap_last, tap_issue;
    logic [AW-1:0]           tap_addr;

    always_comb begin
        case (r_phase)
            PH_GRAD: begin
                win_n   = WIN_W'(3);
                win_off = WIN_W'(1);
                base_r  = r_pr[1];
                base_c  = r_pc[1];
            end
            PH_RESP: begin
                win_n   = WIN_W'(6);
                win_off = WIN_W'(2);
                base_r  = r_pr[2];
                base_c  = r_pc[2];
            end
            default: begin
                win_n   = WIN_W'(NMS_N);
                win_off = WIN_W'(NMS_RADIUS);
                base_r  = r_pr[3];
                base_c  = r_pc[3];
            end
        endcase
        tap_r = $signed({2'b00, base_r}) + $signed(TR_W'(r_tr)) - $signed(TR_W'(win_off));
        tap_c = $signed({2'b00, base_c}) + $signed(TC_W'(r_tc)) - $signed(TC_W'(win_off));
        tap_in = !tap_r[TR_W-1] && (tap_r[ROW_W:0] < r_h) &&
                 !tap_c[TC_W-1] &&
                 ((COLW+IMG_W_W+1)'(tap_c[COLW:0]) < (COLW+IMG_W_W+1)'(r_w));
        tap_addr  = {tap_r[RING_W-1:0], tap_c[COLW-1:0]};
        tap_last  = (r_tr == win_n - WIN_W'(1)) && (r_tc == win_n - WIN_W'(1));
        tap_issue = (r_state == S_TAP) && !r_iss_done;
    end

    // Line memories.
    logic              pix_we;
    logic [AW-1:0]     pix_waddr;
    logic [PIX_W-1:0]  pix_wdata, pix_rdata;
    logic [GPAIR_W-1:0] grd_rdata;
    logic [RESP_W-1:0] rsp_rdata;

    always_comb begin
        pix_we    = (r_state == S_CLEAR) || ((r_state == S_STORE) && r_en[0]);
        pix_waddr = (r_state == S_CLEAR) ? r_clr_addr : {r_pr[0][RING_W-1:0], r_pc[0]};
        pix_wdata = ((r_state == S_CLEAR) || r_op) ? '0 : r_pix;
    end

    hcd_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_pix_ram (
        .i_clk   (i_clk),
        .i_we    (pix_we),
        .i_waddr (pix_waddr),
        .i_wdata (pix_wdata),
        .i_raddr (tap_addr),
        .o_rdata (pix_rdata)
    );

    hcd_ram #(.WIDTH(GPAIR_W), .DEPTH(DEPTH)) u_grd_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_GRAD_WR),
        .i_waddr ({r_pr[1][RING_W-1:0], r_pc[1]}),
        .i_wdata ({r_gy, r_gx}),
        .i_raddr (tap_addr),
        .o_rdata (grd_rdata)
    );

    hcd_ram #(.WIDTH(RESP_W), .DEPTH(DEPTH)) u_rsp_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_RESP_WR),
        .i_waddr ({r_pr[2][RING_W-1:0], r_pc[2]}),
        .i_wdata (r_rq),
        .i_raddr (tap_addr),
        .o_rdata (rsp_rdata)
    );

    hcd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_div_req),
        .o_rsp   (div_rsp)
    );

    // Datapath helpers.
    logic signed [GRAD_W-1:0] pix_s, ix, iy;
    logic [ACC_W-1:0]         sxx_r, syy_r, sxy_abs, sxy_r;
    logic [NUM_W-1:0]         num_c;
    logic                     out_ok;
    logic [COLW:0]            col_p1;
    logic [OCOL_W+COLW-1:0]   col_ext;

    always_comb begin
        pix_s   = $signed({3'b000, pix_rdata});
        ix      = $signed(grd_rdata[GRAD_W-1:0]);
        iy      = $signed(grd_rdata[GPAIR_W-1:GRAD_W]);
        sxx_r   = r_sxx + ACC_W'(2048);
        syy_r   = r_syy + ACC_W'(2048);
        sxy_abs = r_sxy[ACC_W-1] ? ACC_W'(-r_sxy) : r_sxy;
        sxy_r   = sxy_abs + ACC_W'(2048);
        num_c   = (r_ab > r_cc) ? r_ab - r_cc : '0;
        out_ok  = !r_en[3] || !r_out_vld || i_m_axis_tready;
        col_ext = (OCOL_W+COLW)'(r_pc[3]);
        // Raster advance, or return to the frame start.
        col_p1  = (COLW+1)'(r_in_col) + (COLW+1)'(1);
        if (!r_adv) begin
            n_in_row = '0;
            n_in_col = '0;
        end else if ((COLW+IMG_W_W+1)'(col_p1) >= (COLW+IMG_W_W+1)'(r_w)) begin
            n_in_row = r_in_row + IMG_H_W'(1);
            n_in_col = '0;
        end else begin
            n_in_row = r_in_row;
            n_in_col = col_p1[COLW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_phase    <= PH_GRAD;
            r_clr_addr <= '0;
            r_img_w    <= IMG_W_W'(640);
            r_img_h    <= IMG_H_W'(480);
            r_thr      <= THR_W'(100);
            r_in_row   <= '0;
            r_in_col   <= '0;
            r_out_vld  <= 1'b0;
            r_s1_vld   <= 1'b0;
            r_s2_vld   <= 1'b0;
            r_s3_vld   <= 1'b0;
            r_div_req  <= '0;
            r_iss_done <= 1'b0;
            r_drain    <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_IMAGE_WIDTH:  r_img_w <= i_cfg_data[IMG_W_W-1:0];
                    CFG_IMAGE_HEIGHT: r_img_h <= i_cfg_data[IMG_H_W-1:0];
                    CFG_THRESHOLD:    r_thr   <= i_cfg_data;
                    default:          ;
                endcase
            end

            // The output register empties unless a new result is loaded in the same cycle.
            if (r_out_vld && i_m_axis_tready &&
                !((r_state == S_FIN) && out_ok && r_en[3])) begin
                r_out_vld <= 1'b0;
            end

            // Tap pipeline: issue, read data, products, weighted products.
            r_s1_vld <= tap_issue && tap_in;
            r_s1_tr  <= r_tr;
            r_s1_tc  <= r_tc;
            r_s1_ctr <= (r_tr == win_off) && (r_tc == win_off);
            r_s2_vld <= r_s1_vld;
            r_pxx    <= GPAIR_W'(ix * ix);
            r_pyy    <= GPAIR_W'(iy * iy);
            r_pxy    <= GPAIR_W'(ix * iy);
            r_s2_wt  <= gauss_weight(r_s1_tr, r_s1_tc);
            r_s3_vld <= r_s2_vld;
            r_wxx    <= ACC_W'(r_pxx * $signed({1'b0, r_s2_wt}));
            r_wyy    <= ACC_W'(r_pyy * $signed({1'b0, r_s2_wt}));
            r_wxy    <= ACC_W'(r_pxy * $signed({1'b0, r_s2_wt}));

            if (r_s1_vld && (r_phase == PH_GRAD)) begin
                if (r_s1_tc == WIN_W'(0)) begin
                    r_gx <= r_gx + pix_s;
                end else if (r_s1_tc == WIN_W'(2)) begin
                    r_gx <= r_gx - pix_s;
                end
                if (r_s1_tr == WIN_W'(0)) begin
                    r_gy <= r_gy + pix_s;
                end else if (r_s1_tr == WIN_W'(2)) begin
                    r_gy <= r_gy - pix_s;
                end
            end
            if (r_s3_vld && (r_phase == PH_RESP)) begin
                r_sxx <= r_sxx + r_wxx;
                r_syy <= r_syy + r_wyy;
                r_sxy <= r_sxy + r_wxy;
            end
            if (r_s1_vld && (r_phase == PH_NMS)) begin
                if (rsp_rdata > r_mx) begin
                    r_mx <= rsp_rdata;
                end
                if (r_s1_ctr) begin
                    r_ctr <= rsp_rdata;
                end
            end

            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == {AW{1'b1}}) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_op    <= i_s_axis_tuser[0];
                        r_pix   <= i_s_axis_tdata;
                        r_state <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    r_w     <= w_eff;
                    r_h     <= h_eff;
                    r_idx   <= POS_W'(r_in_row * w_eff) + POS_W'(r_in_col);
                    r_hw    <= POS_W'(w_eff * h_eff);
                    r_lag_g <= lag_g_c;
                    r_lag_s <= lag_g_c << 2;
                    r_lag_o <= POS_W'(lag_g_c * POS_W'(LAG_O_MUL));
                    r_state <= S_FLAGS;
                end
                S_FLAGS: begin
                    r_en    <= {en_o, en_s, en_g, r_idx < r_hw};
                    r_last  <= last_c;
                    r_adv   <= !ge_o || (en_o && !last_c);
                    r_dsel  <= '0;
                    r_state <= S_DIV_GO;
                end
                S_DIV_GO: begin
                    if (r_en[r_dsel]) begin
                        r_div_req <= '{start: 1'b1, iters: ITERS_POS,
                                       dividend: {div_val, (NUM_W-POS_W)'(0)},
                                       divisor: DEN_W'(r_w)};
                        r_state   <= S_DIV_WAIT;
                    end else if (r_dsel == 2'd3) begin
                        r_state <= S_STORE;
                    end else begin
                        r_dsel <= r_dsel + 2'd1;
                    end
                end
                S_DIV_WAIT: begin
                    // The start pulse lasts one cycle.
                    r_div_req.start <= 1'b0;
                    if (div_rsp.done) begin
                        r_pr[r_dsel] <= div_rsp.quot[ROW_W-1:0];
                        r_pc[r_dsel] <= div_rsp.rem[COLW-1:0];
                        if (r_dsel == 2'd3) begin
                            r_state <= S_STORE;
                        end else begin
                            r_dsel  <= r_dsel + 2'd1;
                            r_state <= S_DIV_GO;
                        end
                    end
                end
                S_STORE, S_GRAD_WR, S_RESP_WR: begin
                    r_tr       <= '0;
                    r_tc       <= '0;
                    r_iss_done <= 1'b0;
                    r_drain    <= '0;
                    r_gx       <= '0;
                    r_gy       <= '0;
                    r_sxx      <= '0;
                    r_syy      <= '0;
                    r_sxy      <= '0;
                    r_mx       <= '0;
                    if ((r_state == S_STORE) && r_en[1]) begin
                        r_phase <= PH_GRAD;
                        r_state <= S_TAP;
                    end else if ((r_state != S_RESP_WR) && r_en[2]) begin
                        r_phase <= PH_RESP;
                        r_state <= S_TAP;
                    end else if (r_en[3]) begin
                        r_phase <= PH_NMS;
                        r_state <= S_TAP;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_TAP: begin
                    if (!r_iss_done) begin
                        if (tap_last) begin
                            r_iss_done <= 1'b1;
                        end else if (r_tc == win_n - WIN_W'(1)) begin
                            r_tc <= '0;
                            r_tr <= r_tr + WIN_W'(1);
                        end else begin
                            r_tc <= r_tc + WIN_W'(1);
                        end
                    end else if (r_drain != 2'd3) begin
                        r_drain <= r_drain + 2'd1;
                    end else begin
                        case (r_phase)
                            PH_GRAD: r_state <= S_GRAD_WR;
                            PH_RESP: r_state <= S_ABC;
                            default: r_state <= S_FIN;
                        endcase
                    end
                end
                S_ABC: begin
                    r_a     <= sxx_r[ACC_W-1:12];
                    r_b     <= syy_r[ACC_W-1:12];
                    r_c     <= sxy_r[ACC_W-1:12];
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_ab    <= r_a * r_b;
                    r_cc    <= r_c * r_c;
                    r_den   <= DEN_W'(r_a) + DEN_W'(r_b);
                    r_state <= S_NUM;
                end
                S_NUM: begin
                    r_div_req <= '{start: 1'b1, iters: ITERS_RESP,
                                   dividend: num_c, divisor: r_den};
                    r_state   <= S_QDIV_WAIT;
                end
                S_QDIV_WAIT: begin
                    r_div_req.start <= 1'b0;
                    if (div_rsp.done) begin
                        // A zero divisor means a flat window: response zero.
                        if (r_den == '0) begin
                            r_rq <= '0;
                        end else if (div_rsp.quot > NUM_W'(RESP_MAX)) begin
                            r_rq <= RESP_MAX;
                        end else begin
                            r_rq <= div_rsp.quot[RESP_W-1:0];
                        end
                        r_state <= S_RESP_WR;
                    end
                end
                S_FIN: begin
                    if (out_ok) begin
                        if (r_en[3]) begin
                            r_out_vld    <= 1'b1;
                            r_out_row    <= r_pr[3];
                            r_out_col    <= col_ext[OCOL_W-1:0];
                            r_out_resp   <= r_ctr;
                            r_out_corner <= (r_ctr == r_mx) && (r_ctr > {r_thr, 4'b0000});
                            r_out_last   <= r_last;
                        end
                        r_in_row <= n_in_row;
                        r_in_col <= n_in_col;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {3'b000, r_out_resp, r_out_col, r_out_row};
    assign o_m_axis_tuser  = r_out_corner;
    assign o_m_axis_tlast  = r_out_last;

endmodule

// File: tb/tb_harris_corner_detector_unit.sv
`timescale 1ns / 100ps

module tb_harris_corner_detector_unit;
    import hcd_pkg::*;

    typedef struct packed {
        logic [11:0] row;
        logic [9:0]  col;
        logic [22:0] resp;
        logic        corner;
        logic        last;
    } t_corner_res;

    localparam int OP_PUSH  = 0;
    localparam int OP_DRAIN = 1;
    localparam int RING     = 16;
    localparam int MAXW     = 1024;
    localparam int NMS_R    = 2;
    localparam int SETTLE   = 400;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_axis_tvalid;
    logic                 o_s_axis_tready;
    logic [7:0]           i_s_axis_tdata;
    logic [0:0]           i_s_axis_tuser;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready;
    logic [47:0]          o_m_axis_tdata;
    logic [0:0]           o_m_axis_tuser;
    logic                 o_m_axis_tlast;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [THR_W-1:0]     i_cfg_data;

    harris_corner_detector_unit uut (.*);

    // Predictor state: its own copy of the line rings, the raster position and the registers.
    logic [7:0]  pix_ring [RING][MAXW];
    int          gx_ring  [RING][MAXW];
    int          gy_ring  [RING][MAXW];
    int unsigned resp_ring[RING][MAXW];
    int unsigned cur_width, cur_height, cur_thresh;
    int unsigned pos_row, pos_col;

    t_corner_res expected_q[$];
    int          fail_count;
    bit          no_idle;
    int          items_sent;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int unsigned eff_w();
        if (cur_width < 1) return 1;
        if (cur_width > MAXW) return MAXW;
        return cur_width;
    endfunction

    function automatic int unsigned eff_h();
        if (cur_height < 1) return 1;
        if (cur_height > 4096) return 4096;
        return cur_height;
    endfunction

    // Ix is left column minus right column, Iy is top row minus bottom row.
    function automatic void calc_gradient(int r, int c, int w, int h);
        int sx;
        int sy;
        int p;
        sx = 0;
        sy = 0;
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                if (r + dr >= 0 && r + dr < h && c + dc >= 0 && c + dc < w) begin
                    p = int'(pix_ring[(r + dr) & (RING - 1)][c + dc]);
                    sx += p * (-dc);
                    sy += p * (-dr);
                end
            end
        end
        gx_ring[r & (RING - 1)][c] = sx;
        gy_ring[r & (RING - 1)][c] = sy;
    endfunction

    function automatic longint gauss_q16(int tr, int tc);
        int mr;
        int mc;
        mr = (tr < 3) ? tr : 5 - tr;
        mc = (tc < 3) ? tc : 5 - tc;
        case (mr * 3 + mc)
            0: return 20;
            1, 3: return 151;
            2, 6: return 406;
            4: return 1101;
            5, 7: return 3002;
            default: return 8153;
        endcase
    endfunction

    function automatic void calc_response(int r, int c, int w, int h);
        longint sxx;
        longint syy;
        longint sxy;
        longint ix;
        longint iy;
        longint wt;
        longint a;
        longint b;
        longint cm;
        longint num;
        longint q;
        sxx = 0;
        syy = 0;
        sxy = 0;
        for (int dr = -2; dr <= 3; dr++) begin
            for (int dc = -2; dc <= 3; dc++) begin
                if (r + dr >= 0 && r + dr < h && c + dc >= 0 && c + dc < w) begin
                    ix = gx_ring[(r + dr) & (RING - 1)][c + dc];
                    iy = gy_ring[(r + dr) & (RING - 1)][c + dc];
                    wt = gauss_q16(dr + 2, dc + 2);
                    sxx += ix * ix * wt;
                    syy += iy * iy * wt;
                    sxy += ix * iy * wt;
                end
            end
        end
        a   = (sxx + 2048) >>> 12;
        b   = (syy + 2048) >>> 12;
        cm  = ((sxy < 0 ? -sxy : sxy) + 2048) >>> 12;
        num = (a * b > cm * cm) ? a * b - cm * cm : 0;
        // A zero divisor gives a zero response.
        q   = (a + b == 0) ? 0 : num / (a + b);
        if (q > 64'd8388607) q = 8388607;
        resp_ring[r & (RING - 1)][c] = int'(q);
    endfunction

    function automatic t_corner_res calc_result(int r, int c, int w, int h);
        t_corner_res res;
        int unsigned v;
        int unsigned mx;
        v  = resp_ring[r & (RING - 1)][c];
        mx = 0;
        for (int dr = -NMS_R; dr <= NMS_R; dr++) begin
            for (int dc = -NMS_R; dc <= NMS_R; dc++) begin
                if (r + dr >= 0 && r + dr < h && c + dc >= 0 && c + dc < w &&
                    resp_ring[(r + dr) & (RING - 1)][c + dc] > mx) begin
                    mx = resp_ring[(r + dr) & (RING - 1)][c + dc];
                end
            end
        end
        res.row    = 12'(r);
        res.col    = 10'(c);
        res.resp   = 23'(v);
        res.corner = (v == mx && longint'(v) > longint'(cur_thresh) * 16);
        res.last   = 1'b0;
        return res;
    endfunction

    // Advances the predictor by one accepted transaction and queues any result it causes.
    function automatic void predict_corner(int op, logic [7:0] pix);
        int unsigned w;
        int unsigned h;
        int unsigned hw;
        int unsigned idx;
        int unsigned o;
        bit          advance;
        t_corner_res res;
        w       = eff_w();
        h       = eff_h();
        hw      = w * h;
        idx     = pos_row * w + pos_col;
        advance = 1'b1;
        if (idx < hw) pix_ring[(idx / w) & (RING - 1)][idx % w] = (op == OP_DRAIN) ? 8'd0 : pix;
        if (idx >= w + 1 && idx - (w + 1) < hw)
            calc_gradient((idx - w - 1) / w, (idx - w - 1) % w, w, h);
        if (idx >= 4 * (w + 1) && idx - 4 * (w + 1) < hw)
            calc_response((idx - 4 * (w + 1)) / w, (idx - 4 * (w + 1)) % w, w, h);
        if (idx >= (4 + NMS_R) * (w + 1)) begin
            o = idx - (4 + NMS_R) * (w + 1);
            if (o < hw) begin
                res = calc_result(o / w, o % w, w, h);
                if (o == hw - 1) begin
                    res.last = 1'b1;
                    advance  = 1'b0;
                end
                expected_q.push_back(res);
            end else begin
                advance = 1'b0;
            end
        end
        if (advance) begin
            pos_col++;
            if (pos_col >= w) begin
                pos_col = 0;
                pos_row++;
            end
        end else begin
            pos_row = 0;
            pos_col = 0;
        end
    endfunction

    // Result side: random backpressure, and every accepted transaction is checked in order.
    always @(posedge i_clk) begin
        i_m_axis_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 25);
    end

    always @(posedge i_clk) begin
        t_corner_res exp_res;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_q.size() == 0) begin
                $error("result transaction with nothing expected: tdata=%h", o_m_axis_tdata);
                fail_count++;
            end else begin
                exp_res = expected_q.pop_front();
                if (o_m_axis_tdata[11:0] !== exp_res.row) begin
                    $error("out_row: expected %0d, got %0d", exp_res.row, o_m_axis_tdata[11:0]);
                    fail_count++;
                end
                if (o_m_axis_tdata[21:12] !== exp_res.col) begin
                    $error("out_col: expected %0d, got %0d", exp_res.col, o_m_axis_tdata[21:12]);
                    fail_count++;
                end
                if (o_m_axis_tdata[44:22] !== exp_res.resp) begin
                    $error("corner_response: expected %0d, got %0d", exp_res.resp,
                           o_m_axis_tdata[44:22]);
                    fail_count++;
                end
                if (o_m_axis_tuser[0] !== exp_res.corner) begin
                    $error("is_corner: expected %0d, got %0d", exp_res.corner,
                           o_m_axis_tuser[0]);
                    fail_count++;
                end
                if (o_m_axis_tlast !== exp_res.last) begin
                    $error("last_of_frame: expected %0d, got %0d", exp_res.last,
                           o_m_axis_tlast);
                    fail_count++;
                end
            end
        end
    end

    // Sends one pixel-stream transaction; valid stays high into the next send unless we idle.
    task automatic send_pixel(int op, logic [7:0] pix);
        while (!no_idle && $urandom_range(99) < 25) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= pix;
        i_s_axis_tuser  <= 1'(op);
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        predict_corner(op, pix);
        items_sent++;
    endtask

    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        // Drain items after the last result may still be in flight.
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] index, int unsigned value);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= THR_W'(value);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (index)
            CFG_IMAGE_WIDTH:  cur_width  = value & 32'h7FF;
            CFG_IMAGE_HEIGHT: cur_height = value & 32'h1FFF;
            CFG_THRESHOLD:    cur_thresh = value & 32'h7FFFF;
            default: ;
        endcase
    endtask

    // Pixel with a strong bias toward black and white so that real corners appear.
    function automatic logic [7:0] pick_pixel();
        case ($urandom_range(3))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    // One whole frame followed by exactly enough drains to flush it; drain_pct sets
    // how often a drain or a stray push replaces the normal transaction.
    task automatic run_frame(int drain_pct);
        int unsigned w;
        int unsigned npix;
        w    = eff_w();
        npix = w * eff_h();
        for (int unsigned k = 0; k < npix; k++)
            send_pixel(($urandom_range(99) < drain_pct) ? OP_DRAIN : OP_PUSH, pick_pixel());
        for (int unsigned k = 0; k < (4 + NMS_R) * (w + 1); k++)
            send_pixel(($urandom_range(99) < drain_pct) ? OP_PUSH : OP_DRAIN, pick_pixel());
    endtask

    task automatic set_geometry(int unsigned w, int unsigned h, int unsigned thr);
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        write_reg(CFG_THRESHOLD, thr);
    endtask

    // A 2x2 frame with the extreme grey levels, a drain inside the frame and a push
    // past the frame end, at threshold zero.
    task automatic test_directed_small();
        set_geometry(2, 2, 0);
        send_pixel(OP_PUSH, 8'd255);
        send_pixel(OP_PUSH, 8'd0);
        send_pixel(OP_DRAIN, 8'd255);
        send_pixel(OP_PUSH, 8'd255);
        send_pixel(OP_PUSH, 8'd170);
        for (int k = 1; k < 18; k++) send_pixel(OP_DRAIN, 8'd85);
    endtask

    // Zero width and height are used as one; a flat 5x3 frame at threshold zero follows.
    task automatic test_zero_geometry();
        set_geometry(0, 0, 524287);
        run_frame(30);
        set_geometry(5, 3, 0);
        for (int k = 0; k < 15 + 36; k++) send_pixel(OP_PUSH, 8'd77);
    endtask

    // Out-of-range register values clamp; a one-column image at the top threshold follows.
    task automatic test_extreme_regs();
        set_geometry(2047, 8191, 524287);
        set_geometry(1, 6, 524287);
        run_frame(10);
        set_geometry(1024, 1, 0);
        set_geometry(9, 1, 0);
        run_frame(10);
    endtask

    task automatic test_random_frames();
        int frame_no;
        frame_no = 0;
        while (items_sent < 1300) begin
            set_geometry($urandom_range(3, 12), $urandom_range(2, 9),
                         ($urandom_range(3) == 0) ? $urandom_range(524287)
                                                  : $urandom_range(2000));
            // One frame runs with both sides streaming back to back.
            no_idle = (frame_no == 3);
            run_frame(($urandom_range(4) == 0) ? 25 : 2);
            no_idle = 1'b0;
            frame_no++;
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = '0;
        i_m_axis_tready = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        fail_count      = 0;
        no_idle         = 1'b0;
        items_sent      = 0;
        cur_width       = 640;
        cur_height      = 480;
        cur_thresh      = 100;
        pos_row         = 0;
        pos_col         = 0;
        for (int r = 0; r < RING; r++) begin
            for (int c = 0; c < MAXW; c++) begin
                pix_ring[r][c]  = '0;
                gx_ring[r][c]   = 0;
                gy_ring[r][c]   = 0;
                resp_ring[r][c] = 0;
            end
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_small();
        test_zero_geometry();
        test_extreme_regs();
        test_random_frames();

        i_s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
